// ===== sv/mtf_pkg.sv =====
// Shared constants for the member table fan-out core.
package mtf_pkg;

  localparam int unsigned TableSlotsDef = 5;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned KindW = 3;
  localparam int unsigned SlotW = 3;
  localparam int unsigned IpW   = 32;
  localparam int unsigned PortW = 16;

  // request kinds
  localparam logic [CmdW-1:0] CMD_JOIN  = 2'd0;
  localparam logic [CmdW-1:0] CMD_LEAVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_MSG   = 2'd2;

  // result kinds
  localparam logic [KindW-1:0] KIND_JOINED  = 3'd0;
  localparam logic [KindW-1:0] KIND_REFUSED = 3'd1;
  localparam logic [KindW-1:0] KIND_LEFT    = 3'd2;
  localparam logic [KindW-1:0] KIND_JNOTICE = 3'd3;
  localparam logic [KindW-1:0] KIND_LNOTICE = 3'd4;
  localparam logic [KindW-1:0] KIND_FWD     = 3'd5;

  // slot number for "not a member"
  localparam logic [SlotW-1:0] NO_SLOT = 3'd7;

endpackage

// ===== sv/member_table_fanout_core.sv =====
// Member table fan-out core: membership table, lookup sequencer and result fan-out.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request beat: cmd, sender
//   address and port, and the has_text flag. Output channel (out_valid_o /
//   out_ready_i) carries result beats; last_o marks the final beat of a request.
//   A request causes zero to TABLE_SLOTS result beats.
//
// Timing:
//   The request is accepted only while the sequencer is idle. A single comparator
//   walks the table one slot per cycle, then a decide state sends the ack, if the
//   request has one, and waits while the output register is full. The fan-out then
//   steps the slots one per cycle up to the last target and sends a beat at each
//   target, holding while the receiver stalls.
//
// Reset clears all valid bits, the member count and the sequencer; addresses and
// ports of the slots are only read while their valid bit is set.
// When the receiver stalls, the output register holds its beat and the sequencer
// waits; the next request may be accepted while the final beat still waits.
module member_table_fanout_core #(
  parameter int unsigned TABLE_SLOTS = mtf_pkg::TableSlotsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [mtf_pkg::CmdW-1:0]   cmd_i,
  input  logic [mtf_pkg::IpW-1:0]    src_ip_i,
  input  logic [mtf_pkg::PortW-1:0]  src_port_i,
  input  logic                       has_text_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mtf_pkg::KindW-1:0]  kind_o,
  output logic [mtf_pkg::IpW-1:0]    dest_ip_o,
  output logic [mtf_pkg::PortW-1:0]  dest_port_o,
  output logic [mtf_pkg::SlotW-1:0]  dest_slot_o,
  output logic [mtf_pkg::SlotW-1:0]  about_slot_o,
  output logic                       last_o
);
  import mtf_pkg::*;

  localparam int unsigned IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_FAN    = 2'd3;

  // table
  logic [TABLE_SLOTS-1:0] entry_valid_q, entry_valid_d;
  logic [IpW-1:0]         entry_ip_q   [TABLE_SLOTS];
  logic [PortW-1:0]       entry_port_q [TABLE_SLOTS];
  logic [SlotW-1:0]       member_count_q, member_count_d;
  logic                   tbl_we;
  logic [IdxW-1:0]        tbl_waddr;

  // sequencer
  logic [1:0]             state_q, state_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [CmdW-1:0]        cmd_q;
  logic [IpW-1:0]         ip_q;
  logic [PortW-1:0]       port_q;
  logic                   text_q;
  logic [SlotW-1:0]       me_q, me_d;
  logic [SlotW-1:0]       free_q, free_d;
  logic [SlotW-1:0]       subj_q, subj_d;
  logic [KindW-1:0]       fan_kind_q, fan_kind_d;
  logic [TABLE_SLOTS-1:0] fan_q, fan_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [KindW-1:0]       kind_q, kind_d;
  logic [IpW-1:0]         dip_q, dip_d;
  logic [PortW-1:0]       dport_q, dport_d;
  logic [SlotW-1:0]       dslot_q, dslot_d;
  logic [SlotW-1:0]       aslot_q, aslot_d;
  logic                   last_q, last_d;
  logic                   load_out;

  logic                   in_fire;
  logic                   out_free;
  logic                   slot_match;
  logic [SlotW-1:0]       sel_slot;
  logic [TABLE_SLOTS-1:0] sel_onehot;
  logic [TABLE_SLOTS-1:0] fan_mask;
  logic [TABLE_SLOTS-1:0] fan_rest;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // shared comparator on the slot under the scan index
  assign slot_match = entry_valid_q[idx_q] && (entry_ip_q[idx_q] == ip_q) &&
                      (entry_port_q[idx_q] == port_q);

  assign sel_slot = (cmd_q == CMD_JOIN) ? free_q : me_q;

  always_comb begin
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      sel_onehot[s] = (sel_slot == SlotW'(s));
    end
  end

  // notice targets: everyone valid except the subject slot
  assign fan_mask = entry_valid_q & ~sel_onehot;
  assign fan_rest = fan_q & ~(TABLE_SLOTS'(1) << idx_q);

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    me_d           = me_q;
    free_d         = free_q;
    subj_d         = subj_q;
    fan_kind_d     = fan_kind_q;
    fan_d          = fan_q;
    entry_valid_d  = entry_valid_q;
    member_count_d = member_count_q;
    tbl_we         = 1'b0;
    tbl_waddr      = sel_slot[IdxW-1:0];
    load_out       = 1'b0;
    kind_d         = kind_q;
    dip_d          = dip_q;
    dport_d        = dport_q;
    dslot_d        = dslot_q;
    aslot_d        = aslot_q;
    last_d         = last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SCAN;
          idx_d   = '0;
          me_d    = NO_SLOT;
          free_d  = NO_SLOT;
        end
      end

      ST_SCAN: begin
        if (slot_match) begin
          me_d = SlotW'(idx_q);
        end
        if (!entry_valid_q[idx_q] && (free_q == NO_SLOT)) begin
          free_d = SlotW'(idx_q);
        end
        if (idx_q == IdxW'(TABLE_SLOTS - 1)) begin
          state_d = ST_DECIDE;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      ST_DECIDE: begin
        subj_d = sel_slot;
        fan_d  = fan_mask;
        case (cmd_q)
          CMD_JOIN: begin
            if (!text_q) begin
              state_d = ST_IDLE;
            end else if (out_free) begin
              load_out = 1'b1;
              dip_d    = ip_q;
              dport_d  = port_q;
              if (me_q != NO_SLOT) begin
                kind_d  = KIND_REFUSED;
                dslot_d = me_q;
                aslot_d = NO_SLOT;
                last_d  = 1'b1;
                state_d = ST_IDLE;
              end else if ((free_q != NO_SLOT) &&
                           (member_count_q < SlotW'(TABLE_SLOTS))) begin
                tbl_we                           = 1'b1;
                entry_valid_d[free_q[IdxW-1:0]]  = 1'b1;
                member_count_d                   = member_count_q + SlotW'(1);
                kind_d                           = KIND_JOINED;
                dslot_d                          = free_q;
                aslot_d                          = free_q;
                last_d                           = (fan_mask == '0);
                fan_kind_d                       = KIND_JNOTICE;
                state_d = (fan_mask == '0) ? ST_IDLE : ST_FAN;
              end else begin
                kind_d  = KIND_REFUSED;
                dslot_d = NO_SLOT;
                aslot_d = NO_SLOT;
                last_d  = 1'b1;
                state_d = ST_IDLE;
              end
            end
          end
          CMD_LEAVE: begin
            if (me_q == NO_SLOT) begin
              state_d = ST_IDLE;
            end else if (out_free) begin
              entry_valid_d[me_q[IdxW-1:0]] = 1'b0;
              if (member_count_q != '0) begin
                member_count_d = member_count_q - SlotW'(1);
              end
              load_out   = 1'b1;
              kind_d     = KIND_LEFT;
              dip_d      = ip_q;
              dport_d    = port_q;
              dslot_d    = NO_SLOT;
              aslot_d    = me_q;
              last_d     = (fan_mask == '0);
              fan_kind_d = KIND_LNOTICE;
              state_d    = (fan_mask == '0) ? ST_IDLE : ST_FAN;
            end
          end
          CMD_MSG: begin
            fan_kind_d = KIND_FWD;
            if (!text_q || (me_q == NO_SLOT) || (fan_mask == '0)) begin
              state_d = ST_IDLE;
            end else begin
              state_d = ST_FAN;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_FAN: begin
        if (fan_q[idx_q]) begin
          if (out_free) begin
            load_out = 1'b1;
            kind_d   = fan_kind_q;
            dip_d    = entry_ip_q[idx_q];
            dport_d  = entry_port_q[idx_q];
            dslot_d  = SlotW'(idx_q);
            aslot_d  = subj_q;
            last_d   = (fan_rest == '0);
            fan_d    = fan_rest;
            idx_d    = idx_q + IdxW'(1);
            if (fan_rest == '0) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      entry_valid_q  <= '0;
      member_count_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      entry_valid_q  <= entry_valid_d;
      member_count_q <= member_count_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // table storage, no reset
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      entry_ip_q[tbl_waddr]   <= ip_q;
      entry_port_q[tbl_waddr] <= port_q;
    end
  end

  // request capture, sequencer datapath and output beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= cmd_i;
      ip_q   <= src_ip_i;
      port_q <= src_port_i;
      text_q <= has_text_i;
    end
    idx_q      <= idx_d;
    me_q       <= me_d;
    free_q     <= free_d;
    subj_q     <= subj_d;
    fan_kind_q <= fan_kind_d;
    fan_q      <= fan_d;
    kind_q     <= kind_d;
    dip_q      <= dip_d;
    dport_q    <= dport_d;
    dslot_q    <= dslot_d;
    aslot_q    <= aslot_d;
    last_q     <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign dest_ip_o    = dip_q;
  assign dest_port_o  = dport_q;
  assign dest_slot_o  = dslot_q;
  assign about_slot_o = aslot_q;
  assign last_o       = last_q;

  // count tracks the valid bits
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    member_count_q == SlotW'($countones(entry_valid_q)))
    else $error("member count out of step with valid bits");

  // fan-out only runs with targets left
  a_fan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FAN) |-> (fan_q != '0))
    else $error("fan-out state with no targets");

  // subject of a fan-out is a real slot
  a_fan_subject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FAN) |-> (subj_q < SlotW'(TABLE_SLOTS)))
    else $error("fan-out subject slot out of range");

endmodule
